FILE: sv/cpg3_pkg.sv
// Shared constants, types and helpers for the 3-D circle point generator.
`default_nettype none
package cpg3_pkg;

   localparam int ANGLE_STEPS  = 360;
   localparam int FRAC_BITS    = 16;
   localparam int ANGLE_W      = 9;
   localparam int XW           = 2 * ANGLE_W;
   localparam int CORDIC_STEPS = 30;
   localparam int CW           = 34;
   localparam int CSR_IDX_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 3'd6;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

   // phase = floor(a * 2^32 / ANGLE_STEPS), split into integer and fractional steps
   localparam logic [31:0] PHASE_INT   = 32'((64'd1 << 32) / ANGLE_STEPS);
   localparam logic [31:0] PHASE_REM   = 32'((64'd1 << 32) % ANGLE_STEPS);
   localparam logic [32:0] PHASE_RECIP = 33'((64'd1 << 32) / ANGLE_STEPS + 1);

   localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
   };

   typedef struct packed {
      logic                degen;
      logic signed [31:0]  ux;
      logic signed [31:0]  uy;
      logic signed [31:0]  vx;
      logic signed [31:0]  vy;
      logic signed [31:0]  vz;
      logic signed [31:0]  cen_x;
      logic signed [31:0]  cen_y;
      logic signed [31:0]  cen_z;
      logic signed [31:0]  radius;
   } basis_type;

   typedef struct packed {
      logic               valid;
      logic [ANGLE_W-1:0] step;
   } head_type;

   typedef struct packed {
      logic                valid;
      logic signed [CW-1:0] sn;
      logic signed [CW-1:0] cs;
   } trig_type;

   // Q30 product rounding: add half, arithmetic shift right by 30
   function automatic logic signed [37:0] round_q30(input logic signed [67:0] p);
      logic signed [67:0] s;
      s = p + 68'sd536870912;
      return 38'(s >>> 30);
   endfunction

endpackage
`default_nettype wire

FILE: sv/circle_point_generator_3d_top.sv
// Top level of the 3-D circle point generator.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_angle_deg
//   rsp      out        rsp_valid/rsp_ready    rsp_point_x/y/z, rsp_degenerate, rsp_saturated
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One item per cycle sustained while rsp_ready holds and the basis sequencer is idle; items
// pass the two-entry queue, phase stages, 30 CORDIC stages, three point stages, output register.
// After reset and after every normal write the basis sequencer runs (normalize shift, two
// 32-step square roots, four 64-step divides, skipped for a degenerate normal); req_ready
// stays low meanwhile. A stalled rsp freezes the whole back pipeline; the front queue
// keeps taking items until it holds two.
`default_nettype none
module circle_point_generator_3d_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cpg3_pkg::ANGLE_W-1:0]    req_angle_deg,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_point_x,
   output logic signed [31:0]              rsp_point_y,
   output logic signed [31:0]              rsp_point_z,
   output logic                            rsp_degenerate,
   output logic                            rsp_saturated,
   input  logic                            csr_we,
   input  logic [cpg3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_wdata
);
   import cpg3_pkg::*;

   basis_type basis;
   head_type  head;
   trig_type  trig;
   logic      busy;
   logic      pop;
   logic      adv;

   cpg3_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .basis     (basis),
      .busy      (busy)
   );

   cpg3_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_angle_deg (req_angle_deg),
      .basis_busy    (busy),
      .pop           (pop),
      .head          (head)
   );

   cpg3_sincos u_sincos (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .head  (head),
      .pop   (pop),
      .trig  (trig)
   );

   cpg3_point u_point (
      .clock          (clock),
      .reset          (reset),
      .trig           (trig),
      .basis          (basis),
      .adv            (adv),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_z    (rsp_point_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
`default_nettype wire

FILE: sv/cpg3_basis.sv
// Configuration registers and the sequencer that builds the unit basis vectors.
`default_nettype none
module cpg3_basis (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [cpg3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata,
   output cpg3_pkg::basis_type                basis,
   output logic                               busy
);
   import cpg3_pkg::*;

   localparam logic [3:0] ST_ABS   = 4'd0;
   localparam logic [3:0] ST_NORM  = 4'd1;
   localparam logic [3:0] ST_SQX   = 4'd2;
   localparam logic [3:0] ST_SQY   = 4'd3;
   localparam logic [3:0] ST_SQZ   = 4'd4;
   localparam logic [3:0] ST_SUM   = 4'd5;
   localparam logic [3:0] ST_ROOT  = 4'd6;
   localparam logic [3:0] ST_DLOAD = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_VX    = 4'd9;
   localparam logic [3:0] ST_VY    = 4'd10;
   localparam logic [3:0] ST_VZ    = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   logic signed [31:0] nx_ff, ny_ff, nz_ff, cenx_ff, ceny_ff, cenz_ff, rad_ff;
   logic [3:0]         state_ff;
   logic               degen_ff;
   logic [31:0]        ax_ff, ay_ff, az_ff;
   logic signed [65:0] prod_ff;
   logic [63:0]        acc_ff, nl_src_ff;
   logic [63:0]        sq_n_ff, sq_res_ff, sq_bit_ff;
   logic               root_sel_ff;
   logic [31:0]        ul_ff, nl_ff;
   logic [1:0]         div_sel_ff;
   logic [63:0]        dv_num_ff;
   logic [31:0]        dv_den_ff, dv_rem_ff;
   logic               dv_neg_ff;
   logic [6:0]         dv_cnt_ff;
   logic signed [31:0] ux_ff, uy_ff, czq_ff, w_ff, vx_ff, vy_ff, vz_ff;

   logic [31:0]        abs_x, abs_y, abs_z;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [64:0]        sq_sum;
   logic               sq_ge;
   logic [32:0]        rem_sh;
   logic               dv_ge;
   logic [31:0]        rem_nx;
   logic [31:0]        dv_res;
   logic [31:0]        div_mag, div_den;
   logic               div_neg;
   logic signed [37:0] rnd;
   logic               big;

   assign abs_x = nx_ff[31] ? (~nx_ff + 32'd1) : nx_ff;
   assign abs_y = ny_ff[31] ? (~ny_ff + 32'd1) : ny_ff;
   assign abs_z = nz_ff[31] ? (~nz_ff + 32'd1) : nz_ff;
   assign big   = ax_ff[31] | ax_ff[30] | ay_ff[31] | ay_ff[30] | az_ff[31] | az_ff[30];

   // one shared multiplier for squares and the v products
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQX: begin
            mul_a = $signed({1'b0, ax_ff});
            mul_b = $signed({1'b0, ax_ff});
         end
         ST_SQY: begin
            mul_a = $signed({1'b0, ay_ff});
            mul_b = $signed({1'b0, ay_ff});
         end
         ST_SQZ: begin
            mul_a = $signed({1'b0, az_ff});
            mul_b = $signed({1'b0, az_ff});
         end
         ST_VX: begin
            mul_a = -(33'(uy_ff));
            mul_b = 33'(czq_ff);
         end
         ST_VY: begin
            mul_a = 33'(ux_ff);
            mul_b = 33'(czq_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = 66'(mul_a) * 66'(mul_b);
   assign rnd    = round_q30(68'(prod_ff));

   assign sq_sum = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign sq_ge  = {1'b0, sq_n_ff} >= sq_sum;

   assign rem_sh = {dv_rem_ff, dv_num_ff[63]};
   assign dv_ge  = rem_sh >= {1'b0, dv_den_ff};
   assign rem_nx = dv_ge ? 32'(rem_sh - {1'b0, dv_den_ff}) : rem_sh[31:0];
   assign dv_res = dv_neg_ff ? (~dv_num_ff[31:0] + 32'd1) : dv_num_ff[31:0];

   always_comb begin
      case (div_sel_ff)
         2'd0: begin
            div_mag = ay_ff;
            div_den = ul_ff;
            div_neg = ny_ff[31];
         end
         2'd1: begin
            div_mag = ax_ff;
            div_den = ul_ff;
            div_neg = !nx_ff[31];
         end
         2'd2: begin
            div_mag = az_ff;
            div_den = nl_ff;
            div_neg = nz_ff[31];
         end
         default: begin
            div_mag = ul_ff;
            div_den = nl_ff;
            div_neg = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff    <= '0;
         ny_ff    <= '0;
         nz_ff    <= 32'(1 << FRAC_BITS);
         cenx_ff  <= '0;
         ceny_ff  <= '0;
         cenz_ff  <= '0;
         rad_ff   <= '0;
         state_ff <= ST_ABS;
         degen_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_ABS: begin
               ax_ff    <= abs_x;
               ay_ff    <= abs_y;
               az_ff    <= abs_z;
               degen_ff <= (abs_x == '0) && (abs_y == '0);
               state_ff <= ((abs_x == '0) && (abs_y == '0)) ? ST_DONE : ST_NORM;
            end
            ST_NORM: begin
               // scale up until the largest magnitude reaches 2^30
               if (!big) begin
                  ax_ff <= ax_ff << 1;
                  ay_ff <= ay_ff << 1;
                  az_ff <= az_ff << 1;
               end else begin
                  state_ff <= ST_SQX;
               end
            end
            ST_SQX: state_ff <= ST_SQY;
            ST_SQY: begin
               acc_ff   <= 64'(prod_ff);
               state_ff <= ST_SQZ;
            end
            ST_SQZ: begin
               acc_ff   <= acc_ff + 64'(prod_ff);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               nl_src_ff   <= acc_ff + 64'(prod_ff);
               sq_n_ff     <= acc_ff;
               sq_res_ff   <= '0;
               sq_bit_ff   <= 64'd1 << 62;
               root_sel_ff <= 1'b0;
               state_ff    <= ST_ROOT;
            end
            ST_ROOT: begin
               if (sq_bit_ff != '0) begin
                  if (sq_ge) begin
                     sq_n_ff   <= sq_n_ff - sq_sum[63:0];
                     sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
                  end else begin
                     sq_res_ff <= sq_res_ff >> 1;
                  end
                  sq_bit_ff <= sq_bit_ff >> 2;
               end else if (!root_sel_ff) begin
                  ul_ff       <= sq_res_ff[31:0];
                  sq_n_ff     <= nl_src_ff;
                  sq_res_ff   <= '0;
                  sq_bit_ff   <= 64'd1 << 62;
                  root_sel_ff <= 1'b1;
               end else begin
                  nl_ff      <= sq_res_ff[31:0];
                  div_sel_ff <= 2'd0;
                  state_ff   <= ST_DLOAD;
               end
            end
            ST_DLOAD: begin
               dv_num_ff <= {2'b00, div_mag, 30'b0};
               dv_den_ff <= div_den;
               dv_neg_ff <= div_neg;
               dv_rem_ff <= '0;
               dv_cnt_ff <= '0;
               state_ff  <= ST_DIV;
            end
            ST_DIV: begin
               if (!dv_cnt_ff[6]) begin
                  dv_rem_ff <= rem_nx;
                  dv_num_ff <= {dv_num_ff[62:0], dv_ge};
                  dv_cnt_ff <= dv_cnt_ff + 7'd1;
               end else begin
                  case (div_sel_ff)
                     2'd0:    ux_ff  <= dv_res;
                     2'd1:    uy_ff  <= dv_res;
                     2'd2:    czq_ff <= dv_res;
                     default: w_ff   <= dv_res;
                  endcase
                  if (div_sel_ff == 2'd3) begin
                     state_ff <= ST_VX;
                  end else begin
                     div_sel_ff <= div_sel_ff + 2'd1;
                     state_ff   <= ST_DLOAD;
                  end
               end
            end
            ST_VX: state_ff <= ST_VY;
            ST_VY: begin
               vx_ff    <= rnd[31:0];
               state_ff <= ST_VZ;
            end
            ST_VZ: begin
               vy_ff    <= rnd[31:0];
               vz_ff    <= -w_ff;
               state_ff <= ST_DONE;
            end
            default: state_ff <= ST_DONE;
         endcase

         if (csr_we) begin
            case (csr_index)
               CSR_NORMAL_X: nx_ff   <= csr_wdata;
               CSR_NORMAL_Y: ny_ff   <= csr_wdata;
               CSR_NORMAL_Z: nz_ff   <= csr_wdata;
               CSR_CENTER_X: cenx_ff <= csr_wdata;
               CSR_CENTER_Y: ceny_ff <= csr_wdata;
               CSR_CENTER_Z: cenz_ff <= csr_wdata;
               CSR_RADIUS:   rad_ff  <= csr_wdata;
               default: ;
            endcase
            // a new normal restarts the basis build
            if (csr_index == CSR_NORMAL_X || csr_index == CSR_NORMAL_Y ||
                csr_index == CSR_NORMAL_Z) begin
               state_ff <= ST_ABS;
            end
         end
      end
   end

   assign busy         = (state_ff != ST_DONE);
   assign basis.degen  = degen_ff;
   assign basis.ux     = ux_ff;
   assign basis.uy     = uy_ff;
   assign basis.vx     = vx_ff;
   assign basis.vy     = vy_ff;
   assign basis.vz     = vz_ff;
   assign basis.cen_x  = cenx_ff;
   assign basis.cen_y  = ceny_ff;
   assign basis.cen_z  = cenz_ff;
   assign basis.radius = rad_ff;

endmodule
`default_nettype wire

FILE: sv/cpg3_front.sv
// Input acceptance, angle wrap and the two-entry queue to the point pipeline.
`default_nettype none
module cpg3_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cpg3_pkg::ANGLE_W-1:0]    req_angle_deg,
   input  logic                            basis_busy,
   input  logic                            pop,
   output cpg3_pkg::head_type              head
);
   import cpg3_pkg::*;

   logic [ANGLE_W-1:0] ent_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         cnt_ff;
   logic [ANGLE_W-1:0] wrapped;
   logic               push;

   assign wrapped   = (req_angle_deg >= ANGLE_W'(ANGLE_STEPS)) ?
                      (req_angle_deg - ANGLE_W'(ANGLE_STEPS)) : req_angle_deg;
   assign req_ready = !basis_busy && (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= wrapped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.step  = ent_ff[rd_ptr_ff];

endmodule
`default_nettype wire

FILE: sv/cpg3_sincos.sv
// Phase computation and pipelined CORDIC rotation giving sine and cosine.
`default_nettype none
module cpg3_sincos (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  cpg3_pkg::head_type   head,
   output logic                 pop,
   output cpg3_pkg::trig_type   trig
);
   import cpg3_pkg::*;

   logic                 a_valid_ff, b_valid_ff;
   logic [31:0]          a_int_ff;
   logic [XW-1:0]        a_x_ff;
   logic [31:0]          b_phase_ff;
   logic [40:0]          int_p;
   logic [XW+32:0]       fr_p;
   logic [61:0]          zp;

   logic signed [CW-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] z_ff [CORDIC_STEPS+1];
   logic [1:0]           q_ff [CORDIC_STEPS+1];
   logic                 v_ff [CORDIC_STEPS+1];

   logic                 tv_ff;
   logic signed [CW-1:0] tsn_ff, tcs_ff;

   assign pop   = adv && head.valid;
   assign int_p = 41'(head.step) * 41'(PHASE_INT);
   assign fr_p  = (XW+33)'(a_x_ff) * (XW+33)'(PHASE_RECIP);
   assign zp    = 62'(b_phase_ff[29:0]) * 62'(HALF_PI_Q30) + 62'(64'd1 << 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         v_ff[0]    <= 1'b0;
         tv_ff      <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= head.valid;
         b_valid_ff <= a_valid_ff;
         v_ff[0]    <= b_valid_ff;
         tv_ff      <= v_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_int_ff   <= int_p[31:0];
         a_x_ff     <= XW'(head.step) * XW'(PHASE_REM);
         b_phase_ff <= a_int_ff + 32'(fr_p[XW+32:32]);
         // first quadrant angle in Q30 radians, quadrant from the top bits
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= CW'(zp[61:30]);
         q_ff[0]    <= b_phase_ff[31:30];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[i+1] <= q_ff[i];
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - $signed(CW'(ATAN_Q30[i]));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + $signed(CW'(ATAN_Q30[i]));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         case (q_ff[CORDIC_STEPS])
            2'd0: begin
               tcs_ff <= x_ff[CORDIC_STEPS];
               tsn_ff <= y_ff[CORDIC_STEPS];
            end
            2'd1: begin
               tcs_ff <= -y_ff[CORDIC_STEPS];
               tsn_ff <= x_ff[CORDIC_STEPS];
            end
            2'd2: begin
               tcs_ff <= -x_ff[CORDIC_STEPS];
               tsn_ff <= -y_ff[CORDIC_STEPS];
            end
            default: begin
               tcs_ff <= y_ff[CORDIC_STEPS];
               tsn_ff <= -x_ff[CORDIC_STEPS];
            end
         endcase
      end
   end

   assign trig.valid = tv_ff;
   assign trig.sn    = tsn_ff;
   assign trig.cs    = tcs_ff;

endmodule
`default_nettype wire

FILE: sv/cpg3_point.sv
// Point arithmetic: basis combination, radius scaling, centre offset, saturation.
`default_nettype none
module cpg3_point (
   input  logic                 clock,
   input  logic                 reset,
   input  cpg3_pkg::trig_type   trig,
   input  cpg3_pkg::basis_type  basis,
   output logic                 adv,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_point_x,
   output logic signed [31:0]   rsp_point_y,
   output logic signed [31:0]   rsp_point_z,
   output logic                 rsp_degenerate,
   output logic                 rsp_saturated
);
   import cpg3_pkg::*;

   logic               s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic signed [65:0] pux_ff, pvx_ff, puy_ff, pvy_ff, pvz_ff;
   logic signed [33:0] tx_ff, ty_ff, tz_ff;
   logic signed [65:0] rx_ff, ry_ff, rz_ff;
   logic signed [37:0] tx_r, ty_r, tz_r;
   logic signed [37:0] sx, sy, sz;
   logic [32:0]        qx, qy, qz;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic               odeg_ff, osat_ff;

   function automatic logic [32:0] clip32(input logic signed [37:0] v);
      logic [32:0] r;
      if (v > 38'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -38'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   assign adv  = !out_v_ff || rsp_ready;

   assign tx_r = round_q30(68'(pux_ff) + 68'(pvx_ff));
   assign ty_r = round_q30(68'(puy_ff) + 68'(pvy_ff));
   assign tz_r = round_q30(68'(pvz_ff));

   assign sx   = 38'(basis.cen_x) + round_q30(68'(rx_ff));
   assign sy   = 38'(basis.cen_y) + round_q30(68'(ry_ff));
   assign sz   = 38'(basis.cen_z) + round_q30(68'(rz_ff));
   assign qx   = clip32(sx);
   assign qy   = clip32(sy);
   assign qz   = clip32(sz);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= trig.valid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         out_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pux_ff <= 66'($signed(basis.ux)) * 66'($signed(trig.cs));
         pvx_ff <= 66'($signed(basis.vx)) * 66'($signed(trig.sn));
         puy_ff <= 66'($signed(basis.uy)) * 66'($signed(trig.cs));
         pvy_ff <= 66'($signed(basis.vy)) * 66'($signed(trig.sn));
         pvz_ff <= 66'($signed(basis.vz)) * 66'($signed(trig.sn));

         tx_ff  <= 34'(tx_r);
         ty_ff  <= 34'(ty_r);
         tz_ff  <= 34'(tz_r);

         rx_ff  <= 66'($signed(basis.radius)) * 66'(tx_ff);
         ry_ff  <= 66'($signed(basis.radius)) * 66'(ty_ff);
         rz_ff  <= 66'($signed(basis.radius)) * 66'(tz_ff);

         // a degenerate normal returns the centre untouched
         if (basis.degen) begin
            ox_ff   <= basis.cen_x;
            oy_ff   <= basis.cen_y;
            oz_ff   <= basis.cen_z;
            odeg_ff <= 1'b1;
            osat_ff <= 1'b0;
         end else begin
            ox_ff   <= qx[31:0];
            oy_ff   <= qy[31:0];
            oz_ff   <= qz[31:0];
            odeg_ff <= 1'b0;
            osat_ff <= qx[32] | qy[32] | qz[32];
         end
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_point_x    = ox_ff;
   assign rsp_point_y    = oy_ff;
   assign rsp_point_z    = oz_ff;
   assign rsp_degenerate = odeg_ff;
   assign rsp_saturated  = osat_ff;

endmodule
`default_nettype wire
